// ===== rtl/bmc_pkg.sv =====
// shared types and default sizes for the composite-modulus binomial block
// no dependencies; used by the top level for its defaults and its sequencer states
package bmc_pkg;

    localparam int DEF_ARG_BITS    = 60;
    localparam int DEF_MOD_BITS    = 20;
    localparam int DEF_MAX_FACTORS = 8;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CHECK,
        S_TRIAL,
        S_TRIAL_CHK,
        S_EXT_CHK,
        S_STORE,
        S_LAST,
        S_FRD,
        S_FLOAD,
        S_PFX,
        S_PFX_NEXT,
        S_MUL,
        S_DIV,
        S_BLOCK,
        S_UF_START,
        S_UF_LOOP,
        S_UF_Q,
        S_POW,
        S_POW_SQ,
        S_POW_SH,
        S_UF_P1,
        S_UF_P2,
        S_UF_P3,
        S_UF_P4,
        S_UF_R,
        S_UF_END,
        S_DEN,
        S_INV,
        S_V2,
        S_RK,
        S_RES,
        S_OTH,
        S_OTH2,
        S_CRT1,
        S_CRT2,
        S_CRT3,
        S_OUT
    } state_t;

endpackage

// ===== rtl/bmc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// standalone; instantiated by binomial_mod_composite_top
module bmc_div #(
    parameter int NW = 60,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CNW = $clog2(NW + 1);

    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [NW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  den_reg, den_next;
    logic [DW:0]    trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNW'(NW);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[NW-2:0], fits};
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            cnt_next = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/bmc_mulmod.sv =====
// bit-serial modular multiplier, a*b mod m with a, b below m, one bit of b per cycle
// standalone; instantiated by binomial_mod_composite_top
module bmc_mulmod #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] y
);

    localparam int CNW = $clog2(W + 1);

    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   m_reg, m_next;
    logic [W:0]     dbl, dbl_red, add, add_red;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add     = dbl_red + {1'b0, a_reg};
        add_red = (add >= {1'b0, m_reg}) ? add - {1'b0, m_reg} : add;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (start)
        begin
            cnt_next = CNW'(W);
            acc_next = '0;
            a_next   = a;
            b_next   = b;
            m_next   = m;
        end
        else if (cnt_reg != '0)
        begin
            // msb first: double, then add a when the bit is set
            acc_next  = b_reg[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
            b_next    = {b_reg[W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done = done_reg;
    assign y    = acc_reg;

endmodule

// ===== rtl/binomial_mod_composite_top.sv =====
// C(n, m) mod p for any modulus p.
// The input channel (in_valid/in_ready) carries n_value, m_value and modulus; the
// output channel (out_valid/out_ready) carries binomial_residue, one per input item.
// One item is worked at a time. The modulus is split into prime powers by trial
// division; each prime power r^e is stored in a small factor memory as {r, q, phi}.
// A second pass reads the memory entry by entry, forms the r-free parts of n!, m!
// and (n-m)! mod q, the power of r, inverts through phi(q)-1 powers and folds the
// residue into the running CRT sum mod p.
// Latency is data dependent: it grows with the trial division, which runs up to
// sqrt(p), and with the modular products worked for each prime power, which grow
// with q and with the number of base-r digits of n. Items with m above n or modulus
// at most 1 skip the factoring and go straight to the output.
// The modular multiplier and the divider are each a single unit shared by all steps
// and set the rate.
// After reset the block is idle and ready. A finished result waits in the output
// register while the receiver stalls, and the next item is accepted meanwhile;
// a further result is held back until the first has been transferred.
module binomial_mod_composite_top #(
    parameter int ARG_BITS    = bmc_pkg::DEF_ARG_BITS,
    parameter int MOD_BITS    = bmc_pkg::DEF_MOD_BITS,
    parameter int MAX_FACTORS = bmc_pkg::DEF_MAX_FACTORS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ARG_BITS-1:0] n_value,
    input  logic [ARG_BITS-1:0] m_value,
    input  logic [MOD_BITS-1:0] modulus,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MOD_BITS-1:0] binomial_residue
);

    localparam int MB = MOD_BITS;
    localparam int AB = ARG_BITS;
    localparam int DW = (ARG_BITS > MOD_BITS) ? ARG_BITS : MOD_BITS;
    localparam int AW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int EW = 3 * MOD_BITS;

    bmc_pkg::state_t state_reg, state_next;
    bmc_pkg::state_t ret_mul_reg, ret_mul_next;
    bmc_pkg::state_t ret_div_reg, ret_div_next;
    bmc_pkg::state_t ret_pow_reg, ret_pow_next;
    bmc_pkg::state_t ret_pfx_reg, ret_pfx_next;

    logic [AB-1:0] n_reg, n_next, m_reg, m_next;
    logic [AB-1:0] x_reg, x_next, s_reg, s_next, k_reg, k_next;
    logic [MB-1:0] p_reg, p_next, rest_reg, rest_next, d_reg, d_next;
    logic [MB+1:0] dsq_reg, dsq_next;
    logic [MB-1:0] fq_reg, fq_next, fphi_reg, fphi_next;
    logic [CW-1:0] cnt_reg, cnt_next, fidx_reg, fidx_next;
    logic [MB-1:0] r_reg, r_next, q_reg, q_next, phi_reg, phi_next;
    logic [MB-1:0] block_reg, block_next, acc_reg, acc_next, pfx_reg, pfx_next;
    logic [MB-1:0] pres_reg, pres_next, pbase_reg, pbase_next;
    logic [DW-1:0] pexp_reg, pexp_next;
    logic [MB-1:0] den_reg, den_next, v_reg, v_next, res_reg, res_next;
    logic [MB-1:0] oth_reg, oth_next, sum_reg, sum_next, xrem_reg, xrem_next;
    logic [MB:0]   i_reg, i_next;
    logic [MB-1:0] len_reg, len_next, imr_reg, imr_next;
    logic [MB-1:0] muly_reg, muly_next, rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [1:0]    which_reg, which_next;
    logic          outv_reg, outv_next;
    logic [MB-1:0] result_reg, result_next;

    // factor memory: {prime, prime power, totient}
    logic [EW-1:0] fmem [MAX_FACTORS];
    logic [EW-1:0] fmem_rdata_reg;
    logic          fmem_we;
    logic [EW-1:0] fmem_wdata;
    logic [MB-1:0] rd_r, rd_q, rd_phi;

    logic          mul_start, mul_done;
    logic [MB-1:0] mul_a, mul_b, mul_m, mul_y;
    logic          div_start, div_done;
    logic [DW-1:0] div_num, div_quo;
    logic [MB-1:0] div_den, div_rem;

    logic [2*MB-1:0] fq_prod, fphi_prod;
    logic [MB:0]     sum_add;
    logic [MB-1:0]   rbase, imr_inc;
    logic            cnt_room;

    assign rd_r     = fmem_rdata_reg[EW-1 -: MB];
    assign rd_q     = fmem_rdata_reg[2*MB-1 -: MB];
    assign rd_phi   = fmem_rdata_reg[MB-1:0];
    assign fq_prod   = (2*MB)'(fq_reg) * (2*MB)'(d_reg);
    assign fphi_prod = (2*MB)'(fphi_reg) * (2*MB)'(d_reg);
    assign sum_add  = {1'b0, sum_reg} + {1'b0, muly_reg};
    assign rbase    = (r_reg == q_reg) ? '0 : r_reg;
    assign imr_inc  = imr_reg + MB'(1);
    assign cnt_room = cnt_reg < CW'(MAX_FACTORS);

    bmc_mulmod #(.W(MB)) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .m     (mul_m),
        .done  (mul_done),
        .y     (mul_y)
    );

    bmc_div #(.NW(DW), .DW(MB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (fmem_we)
        begin
            fmem[cnt_reg[AW-1:0]] <= fmem_wdata;
        end
        fmem_rdata_reg <= fmem[fidx_reg[AW-1:0]];
    end

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        ret_mul_next = ret_mul_reg;
        ret_div_next = ret_div_reg;
        ret_pow_next = ret_pow_reg;
        ret_pfx_next = ret_pfx_reg;
        n_next = n_reg;  m_next = m_reg;  x_next = x_reg;
        s_next = s_reg;  k_next = k_reg;  p_next = p_reg;
        rest_next = rest_reg;  d_next = d_reg;  dsq_next = dsq_reg;
        fq_next = fq_reg;  fphi_next = fphi_reg;
        cnt_next = cnt_reg;  fidx_next = fidx_reg;
        r_next = r_reg;  q_next = q_reg;  phi_next = phi_reg;
        block_next = block_reg;  acc_next = acc_reg;  pfx_next = pfx_reg;
        pres_next = pres_reg;  pbase_next = pbase_reg;  pexp_next = pexp_reg;
        den_next = den_reg;  v_next = v_reg;  res_next = res_reg;
        oth_next = oth_reg;  sum_next = sum_reg;  xrem_next = xrem_reg;
        i_next = i_reg;  len_next = len_reg;  imr_next = imr_reg;
        muly_next = muly_reg;  rem_next = rem_reg;  quo_next = quo_reg;
        which_next = which_reg;
        result_next = result_reg;
        outv_next = outv_reg & ~out_ready;

        case (state_reg)
            bmc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = n_value;
                    m_next = m_value;
                    p_next = modulus;
                    state_next = bmc_pkg::S_CHECK;
                end
            end
            bmc_pkg::S_CHECK:
            begin
                sum_next = '0;
                cnt_next = '0;
                if (p_reg <= MB'(1) || m_reg > n_reg)
                begin
                    state_next = bmc_pkg::S_OUT;
                end
                else
                begin
                    rest_next  = p_reg;
                    d_next     = MB'(2);
                    dsq_next   = (MB+2)'(4);
                    state_next = bmc_pkg::S_TRIAL;
                end
            end
            bmc_pkg::S_TRIAL:
            begin
                if (dsq_reg > (MB+2)'(rest_reg))
                begin
                    state_next = bmc_pkg::S_LAST;
                end
                else
                begin
                    ret_div_next = bmc_pkg::S_TRIAL_CHK;
                    state_next   = bmc_pkg::S_DIV;
                end
            end
            bmc_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    quo_next   = div_quo;
                    rem_next   = div_rem;
                    state_next = ret_div_reg;
                end
            end
            bmc_pkg::S_TRIAL_CHK:
            begin
                if (rem_reg == '0)
                begin
                    rest_next    = quo_reg[MB-1:0];
                    fq_next      = d_reg;
                    fphi_next    = d_reg - MB'(1);
                    ret_div_next = bmc_pkg::S_EXT_CHK;
                    state_next   = bmc_pkg::S_DIV;
                end
                else
                begin
                    d_next     = d_reg + MB'(1);
                    dsq_next   = dsq_reg + (MB+2)'({d_reg, 1'b1});
                    state_next = bmc_pkg::S_TRIAL;
                end
            end
            bmc_pkg::S_EXT_CHK:
            begin
                if (rem_reg == '0)
                begin
                    rest_next  = quo_reg[MB-1:0];
                    fq_next    = fq_prod[MB-1:0];
                    fphi_next  = fphi_prod[MB-1:0];
                    state_next = bmc_pkg::S_DIV;
                end
                else
                begin
                    state_next = bmc_pkg::S_STORE;
                end
            end
            bmc_pkg::S_STORE:
            begin
                if (cnt_room)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                d_next     = d_reg + MB'(1);
                dsq_next   = dsq_reg + (MB+2)'({d_reg, 1'b1});
                state_next = bmc_pkg::S_TRIAL;
            end
            bmc_pkg::S_LAST:
            begin
                if (rest_reg != MB'(1) && cnt_room)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                fidx_next  = '0;
                state_next = bmc_pkg::S_FRD;
            end
            bmc_pkg::S_FRD:
            begin
                state_next = (fidx_reg == cnt_reg) ? bmc_pkg::S_OUT : bmc_pkg::S_FLOAD;
            end
            bmc_pkg::S_FLOAD:
            begin
                r_next       = rd_r;
                q_next       = rd_q;
                phi_next     = rd_phi;
                pfx_next     = MB'(1);
                i_next       = (MB+1)'(2);
                len_next     = rd_q;
                imr_next     = (rd_r == MB'(2)) ? '0 : MB'(2);
                ret_pfx_next = bmc_pkg::S_BLOCK;
                state_next   = bmc_pkg::S_PFX;
            end
            bmc_pkg::S_PFX:
            begin
                if (i_reg > {1'b0, len_reg})
                begin
                    state_next = ret_pfx_reg;
                end
                else if (imr_reg != '0)
                begin
                    ret_mul_next = bmc_pkg::S_PFX_NEXT;
                    state_next   = bmc_pkg::S_MUL;
                end
                else
                begin
                    // multiple of r: skip the product
                    muly_next  = pfx_reg;
                    state_next = bmc_pkg::S_PFX_NEXT;
                end
            end
            bmc_pkg::S_PFX_NEXT:
            begin
                pfx_next   = muly_reg;
                i_next     = i_reg + (MB+1)'(1);
                imr_next   = (imr_inc == r_reg) ? '0 : imr_inc;
                state_next = bmc_pkg::S_PFX;
            end
            bmc_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    muly_next  = mul_y;
                    state_next = ret_mul_reg;
                end
            end
            bmc_pkg::S_BLOCK:
            begin
                block_next = pfx_reg;
                which_next = 2'd0;
                state_next = bmc_pkg::S_UF_START;
            end
            bmc_pkg::S_UF_START:
            begin
                acc_next = MB'(1);
                s_next   = '0;
                case (which_reg)
                    2'd0:    x_next = n_reg;
                    2'd1:    x_next = m_reg;
                    default: x_next = n_reg - m_reg;
                endcase
                state_next = bmc_pkg::S_UF_LOOP;
            end
            bmc_pkg::S_UF_LOOP:
            begin
                if (x_reg == '0)
                begin
                    state_next = bmc_pkg::S_UF_END;
                end
                else
                begin
                    ret_div_next = bmc_pkg::S_UF_Q;
                    state_next   = bmc_pkg::S_DIV;
                end
            end
            bmc_pkg::S_UF_Q:
            begin
                xrem_next    = rem_reg;
                pres_next    = MB'(1);
                pbase_next   = block_reg;
                pexp_next    = quo_reg;
                ret_pow_next = bmc_pkg::S_UF_P1;
                state_next   = bmc_pkg::S_POW;
            end
            bmc_pkg::S_POW:
            begin
                if (pexp_reg == '0)
                begin
                    state_next = ret_pow_reg;
                end
                else if (pexp_reg[0])
                begin
                    ret_mul_next = bmc_pkg::S_POW_SQ;
                    state_next   = bmc_pkg::S_MUL;
                end
                else
                begin
                    muly_next  = pres_reg;
                    state_next = bmc_pkg::S_POW_SQ;
                end
            end
            bmc_pkg::S_POW_SQ:
            begin
                pres_next    = muly_reg;
                ret_mul_next = bmc_pkg::S_POW_SH;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_POW_SH:
            begin
                pbase_next = muly_reg;
                pexp_next  = pexp_reg >> 1;
                state_next = bmc_pkg::S_POW;
            end
            bmc_pkg::S_UF_P1:
            begin
                ret_mul_next = bmc_pkg::S_UF_P2;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_UF_P2:
            begin
                acc_next     = muly_reg;
                pfx_next     = MB'(1);
                i_next       = (MB+1)'(2);
                len_next     = xrem_reg;
                imr_next     = (r_reg == MB'(2)) ? '0 : MB'(2);
                ret_pfx_next = bmc_pkg::S_UF_P3;
                state_next   = bmc_pkg::S_PFX;
            end
            bmc_pkg::S_UF_P3:
            begin
                ret_mul_next = bmc_pkg::S_UF_P4;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_UF_P4:
            begin
                acc_next     = muly_reg;
                ret_div_next = bmc_pkg::S_UF_R;
                state_next   = bmc_pkg::S_DIV;
            end
            bmc_pkg::S_UF_R:
            begin
                x_next     = quo_reg[AB-1:0];
                s_next     = s_reg + quo_reg[AB-1:0];
                state_next = bmc_pkg::S_UF_LOOP;
            end
            bmc_pkg::S_UF_END:
            begin
                case (which_reg)
                    2'd0:
                    begin
                        v_next     = acc_reg;
                        k_next     = s_reg;
                        which_next = 2'd1;
                        state_next = bmc_pkg::S_UF_START;
                    end
                    2'd1:
                    begin
                        den_next   = acc_reg;
                        k_next     = k_reg - s_reg;
                        which_next = 2'd2;
                        state_next = bmc_pkg::S_UF_START;
                    end
                    default:
                    begin
                        k_next       = k_reg - s_reg;
                        ret_mul_next = bmc_pkg::S_DEN;
                        state_next   = bmc_pkg::S_MUL;
                    end
                endcase
            end
            bmc_pkg::S_DEN:
            begin
                // unit inverse as a power phi(q) - 1
                pres_next    = MB'(1);
                pbase_next   = muly_reg;
                pexp_next    = DW'(phi_reg - MB'(1));
                ret_pow_next = bmc_pkg::S_INV;
                state_next   = bmc_pkg::S_POW;
            end
            bmc_pkg::S_INV:
            begin
                ret_mul_next = bmc_pkg::S_V2;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_V2:
            begin
                v_next       = muly_reg;
                pres_next    = MB'(1);
                pbase_next   = rbase;
                pexp_next    = DW'(k_reg);
                ret_pow_next = bmc_pkg::S_RK;
                state_next   = bmc_pkg::S_POW;
            end
            bmc_pkg::S_RK:
            begin
                ret_mul_next = bmc_pkg::S_RES;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_RES:
            begin
                res_next     = muly_reg;
                ret_div_next = bmc_pkg::S_OTH;
                state_next   = bmc_pkg::S_DIV;
            end
            bmc_pkg::S_OTH:
            begin
                oth_next     = quo_reg[MB-1:0];
                ret_div_next = bmc_pkg::S_OTH2;
                state_next   = bmc_pkg::S_DIV;
            end
            bmc_pkg::S_OTH2:
            begin
                pres_next    = MB'(1);
                pbase_next   = rem_reg;
                pexp_next    = DW'(phi_reg - MB'(1));
                ret_pow_next = bmc_pkg::S_CRT1;
                state_next   = bmc_pkg::S_POW;
            end
            bmc_pkg::S_CRT1:
            begin
                ret_mul_next = bmc_pkg::S_CRT2;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_CRT2:
            begin
                ret_mul_next = bmc_pkg::S_CRT3;
                state_next   = bmc_pkg::S_MUL;
            end
            bmc_pkg::S_CRT3:
            begin
                sum_next   = (sum_add >= {1'b0, p_reg}) ? MB'(sum_add - {1'b0, p_reg})
                                                        : sum_add[MB-1:0];
                fidx_next  = fidx_reg + CW'(1);
                state_next = bmc_pkg::S_FRD;
            end
            bmc_pkg::S_OUT:
            begin
                if (!outv_reg || out_ready)
                begin
                    result_next = sum_reg;
                    outv_next   = 1'b1;
                    state_next  = bmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmc_pkg::S_IDLE;
            end
        endcase
    end

    // unit launches, memory writes and handshake outputs
    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = pfx_reg;
        mul_b      = i_reg[MB-1:0];
        mul_m      = q_reg;
        div_start  = 1'b0;
        div_num    = DW'(x_reg);
        div_den    = q_reg;
        fmem_we    = 1'b0;
        fmem_wdata = {d_reg, fq_reg, fphi_reg};

        case (state_reg)
            bmc_pkg::S_TRIAL:
            begin
                div_start = dsq_reg <= (MB+2)'(rest_reg);
                div_num   = DW'(rest_reg);
                div_den   = d_reg;
            end
            bmc_pkg::S_TRIAL_CHK, bmc_pkg::S_EXT_CHK:
            begin
                div_start = rem_reg == '0;
                div_num   = quo_reg;
                div_den   = d_reg;
            end
            bmc_pkg::S_STORE:
            begin
                fmem_we = cnt_room;
            end
            bmc_pkg::S_LAST:
            begin
                fmem_we    = rest_reg != MB'(1) && cnt_room;
                fmem_wdata = {rest_reg, rest_reg, rest_reg - MB'(1)};
            end
            bmc_pkg::S_PFX:
            begin
                mul_start = i_reg <= {1'b0, len_reg} && imr_reg != '0;
            end
            bmc_pkg::S_UF_LOOP:
            begin
                div_start = x_reg != '0;
            end
            bmc_pkg::S_POW:
            begin
                mul_start = pexp_reg != '0 && pexp_reg[0];
                mul_a     = pres_reg;
                mul_b     = pbase_reg;
            end
            bmc_pkg::S_POW_SQ:
            begin
                mul_start = 1'b1;
                mul_a     = pbase_reg;
                mul_b     = pbase_reg;
            end
            bmc_pkg::S_UF_P1:
            begin
                mul_start = 1'b1;
                mul_a     = acc_reg;
                mul_b     = pres_reg;
            end
            bmc_pkg::S_UF_P3:
            begin
                mul_start = 1'b1;
                mul_a     = acc_reg;
                mul_b     = pfx_reg;
            end
            bmc_pkg::S_UF_P4:
            begin
                div_start = 1'b1;
                div_den   = r_reg;
            end
            bmc_pkg::S_UF_END:
            begin
                mul_start = which_reg == 2'd2;
                mul_a     = den_reg;
                mul_b     = acc_reg;
            end
            bmc_pkg::S_INV, bmc_pkg::S_RK:
            begin
                mul_start = 1'b1;
                mul_a     = v_reg;
                mul_b     = pres_reg;
            end
            bmc_pkg::S_RES:
            begin
                div_start = 1'b1;
                div_num   = DW'(p_reg);
            end
            bmc_pkg::S_OTH:
            begin
                div_start = 1'b1;
                div_num   = quo_reg;
            end
            bmc_pkg::S_CRT1:
            begin
                mul_start = 1'b1;
                mul_a     = res_reg;
                mul_b     = oth_reg;
                mul_m     = p_reg;
            end
            bmc_pkg::S_CRT2:
            begin
                mul_start = 1'b1;
                mul_a     = muly_reg;
                mul_b     = pres_reg;
                mul_m     = p_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign in_ready         = state_reg == bmc_pkg::S_IDLE;
    assign out_valid        = outv_reg;
    assign binomial_residue = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmc_pkg::S_IDLE;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_mul_reg <= ret_mul_next;
        ret_div_reg <= ret_div_next;
        ret_pow_reg <= ret_pow_next;
        ret_pfx_reg <= ret_pfx_next;
        n_reg <= n_next;  m_reg <= m_next;  x_reg <= x_next;
        s_reg <= s_next;  k_reg <= k_next;  p_reg <= p_next;
        rest_reg <= rest_next;  d_reg <= d_next;  dsq_reg <= dsq_next;
        fq_reg <= fq_next;  fphi_reg <= fphi_next;
        cnt_reg <= cnt_next;  fidx_reg <= fidx_next;
        r_reg <= r_next;  q_reg <= q_next;  phi_reg <= phi_next;
        block_reg <= block_next;  acc_reg <= acc_next;  pfx_reg <= pfx_next;
        pres_reg <= pres_next;  pbase_reg <= pbase_next;  pexp_reg <= pexp_next;
        den_reg <= den_next;  v_reg <= v_next;  res_reg <= res_next;
        oth_reg <= oth_next;  sum_reg <= sum_next;  xrem_reg <= xrem_next;
        i_reg <= i_next;  len_reg <= len_next;  imr_reg <= imr_next;
        muly_reg <= muly_next;  rem_reg <= rem_next;  quo_reg <= quo_next;
        which_reg <= which_next;
        result_reg <= result_next;
    end

endmodule
